// ----- rtl/bptc_pkg.sv -----
package bptc_pkg;

	// Field and register widths.
	localparam int unsigned RAW_W = 24;
	localparam int unsigned CAL_W = 16;
	localparam int unsigned OUT_W = 32;
	localparam int unsigned IDX_W = 3;

	// Internal datapath widths, sized to the value ranges of each term.
	localparam int unsigned DT_W   = 25;
	localparam int unsigned PC_W   = 42;
	localparam int unsigned DTSQ_W = 50;
	localparam int unsigned D_W    = 19;
	localparam int unsigned TEMP_W = 20;
	localparam int unsigned T2_W   = 18;
	localparam int unsigned E_W    = 20;
	localparam int unsigned SQ_W   = 36;
	localparam int unsigned CORR_W = 40;
	localparam int unsigned OFF_W  = 42;
	localparam int unsigned SENS_W = 40;
	localparam int unsigned LO_W   = 20;
	localparam int unsigned HI_W   = SENS_W - LO_W;
	localparam int unsigned PLO_W  = RAW_W + LO_W;
	localparam int unsigned PHI_W  = RAW_W + 1 + HI_W;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned PRES_W = 44;

	// Scaling shifts of the compensation formulae.
	localparam int unsigned TEMP_SHIFT = 23;
	localparam int unsigned OFF_SHIFT  = 7;
	localparam int unsigned SENS_SHIFT = 8;
	localparam int unsigned T2_SHIFT   = 31;
	localparam int unsigned MUL_SHIFT  = 21;
	localparam int unsigned P_SHIFT    = 15;

	// 20.00 degC reference, and the distance from it down to -15.00 degC.
	localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);
	localparam logic signed [E_W-1:0]    COLD_GAP = E_W'(3500);

	// Cycles from an accepted start to its done strobe.
	localparam int unsigned LATENCY = 9;

	typedef enum logic [IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} cal_reg_t;

endpackage

// ----- rtl/baro_pressure_temp_compensation_core.sv -----
// An accepted start travels through the valid registers vld_s1 to vld_s9; done is vld_s9.
// Throughput: one word per cycle; busy is never raised, the nine-stage pipeline
// has no stall path because the receiver cannot hold results off.
// The rate is set by the pipelined multipliers, one stage each, and the
// 24 x 40-bit pressure product split into two partial products.
// Reset clears the valid bits and the calibration registers to zero.
module baro_pressure_temp_compensation_core (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic [bptc_pkg::RAW_W-1:0]                 raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]                 raw_temperature,
	output logic                                       done,
	output logic signed [bptc_pkg::OUT_W-1:0]          temperature_centideg,
	output logic signed [bptc_pkg::OUT_W-1:0]          pressure_pa,
	input  logic                                       cfg_wr_en,
	input  logic [bptc_pkg::IDX_W-1:0]                 cfg_index,
	input  logic [bptc_pkg::CAL_W-1:0]                 cfg_data
);

	logic [bptc_pkg::CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// Stage payloads.
	logic        [bptc_pkg::RAW_W-1:0]  d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [bptc_pkg::DT_W-1:0]   dt_s1;
	logic signed [bptc_pkg::PC_W-1:0]   dtc6_s2, dtc4_s2, dtc3_s2;
	logic signed [bptc_pkg::DTSQ_W-1:0] dtsq_s2;
	logic signed [bptc_pkg::D_W-1:0]    d_s3;
	logic        [bptc_pkg::T2_W-1:0]   t2_s3;
	logic signed [bptc_pkg::OFF_W-1:0]  off_s3, off_s4, off_s5, off_s6, off_s7, off_s8;
	logic signed [bptc_pkg::SENS_W-1:0] sens_s3, sens_s4, sens_s5, sens_s6;
	logic        [bptc_pkg::SQ_W-1:0]   dsq_s4, esq_s4;
	logic                               cold_s4, vcold_s4;
	logic signed [bptc_pkg::TEMP_W-1:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic        [bptc_pkg::CORR_W-1:0] off2_s5, sens2_s5;
	logic        [bptc_pkg::PLO_W-1:0]  plo_s7;
	logic signed [bptc_pkg::PHI_W-1:0]  phi_s7;
	logic signed [bptc_pkg::PROD_W-1:0] prod_s8;
	logic signed [bptc_pkg::OUT_W-1:0]  pres_s9;

	// Combinational terms between the stages.
	logic signed [bptc_pkg::DT_W-1:0]   dt_c;
	logic signed [bptc_pkg::D_W-1:0]    d_c;
	logic signed [bptc_pkg::E_W-1:0]    e_c;
	logic signed [2*bptc_pkg::D_W-1:0]  dsq_c;
	logic signed [2*bptc_pkg::E_W-1:0]  esq_c;
	logic signed [bptc_pkg::TEMP_W-1:0] temp_c;
	logic        [bptc_pkg::CORR_W-1:0] five_dsq_c, seven_esq_c, eleven_esq_c;
	logic        [bptc_pkg::CORR_W-1:0] off2_c, sens2_c;
	logic signed [bptc_pkg::PRES_W-1:0] pres_wide_c;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_wr_en) begin
			case (bptc_pkg::cal_reg_t'(cfg_index))
				bptc_pkg::REG_C1: c1_q <= cfg_data;
				bptc_pkg::REG_C2: c2_q <= cfg_data;
				bptc_pkg::REG_C3: c3_q <= cfg_data;
				bptc_pkg::REG_C4: c4_q <= cfg_data;
				bptc_pkg::REG_C5: c5_q <= cfg_data;
				bptc_pkg::REG_C6: c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_comb begin
		dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'h00});

		// The temperature offset from 20 degC; its sign is the first threshold test.
		d_c = dtc6_s2[bptc_pkg::PC_W-1:bptc_pkg::TEMP_SHIFT];

		e_c   = {d_s3[bptc_pkg::D_W-1], d_s3} + bptc_pkg::COLD_GAP;
		dsq_c = d_s3 * d_s3;
		esq_c = e_c * e_c;
		temp_c = {d_s3[bptc_pkg::D_W-1], d_s3} + bptc_pkg::TEMP_REF
			- (d_s3[bptc_pkg::D_W-1] ? {2'b00, t2_s3} : '0);

		five_dsq_c   = bptc_pkg::CORR_W'({dsq_s4, 2'b00}) + bptc_pkg::CORR_W'(dsq_s4);
		seven_esq_c  = bptc_pkg::CORR_W'({esq_s4, 3'b000}) - bptc_pkg::CORR_W'(esq_s4);
		eleven_esq_c = bptc_pkg::CORR_W'({esq_s4, 3'b000}) + bptc_pkg::CORR_W'({esq_s4, 1'b0})
			+ bptc_pkg::CORR_W'(esq_s4);
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			off2_c  = {1'b0, five_dsq_c[bptc_pkg::CORR_W-1:1]};
			sens2_c = {2'b00, five_dsq_c[bptc_pkg::CORR_W-1:2]};
			if (vcold_s4) begin
				off2_c  = off2_c + seven_esq_c;
				sens2_c = sens2_c + {1'b0, eleven_esq_c[bptc_pkg::CORR_W-1:1]};
			end
		end

		pres_wide_c = {prod_s8[bptc_pkg::PROD_W-1], prod_s8[bptc_pkg::PROD_W-1:bptc_pkg::MUL_SHIFT]}
			- {{(bptc_pkg::PRES_W-bptc_pkg::OFF_W){off_s8[bptc_pkg::OFF_W-1]}}, off_s8};
	end

	always_ff @(posedge clk) begin
		// Stage 1: temperature difference.
		d1_s1 <= raw_pressure;
		dt_s1 <= dt_c;

		// Stage 2: the four products of dT.
		d1_s2   <= d1_s1;
		dtc6_s2 <= dt_s1 * $signed({1'b0, c6_q});
		dtc4_s2 <= dt_s1 * $signed({1'b0, c4_q});
		dtc3_s2 <= dt_s1 * $signed({1'b0, c3_q});
		dtsq_s2 <= dt_s1 * dt_s1;

		// Stage 3: first-order offset and sensitivity, and the T2 term.
		d1_s3   <= d1_s2;
		d_s3    <= d_c;
		t2_s3   <= dtsq_s2[bptc_pkg::T2_SHIFT+bptc_pkg::T2_W-1:bptc_pkg::T2_SHIFT];
		off_s3  <= $signed({{(bptc_pkg::OFF_W-32){1'b0}}, c2_q, 16'h0000})
			+ {{bptc_pkg::OFF_SHIFT{dtc4_s2[bptc_pkg::PC_W-1]}},
			dtc4_s2[bptc_pkg::PC_W-1:bptc_pkg::OFF_SHIFT]};
		sens_s3 <= $signed({{(bptc_pkg::SENS_W-31){1'b0}}, c1_q, 15'h0000})
			+ {{(bptc_pkg::SENS_W-bptc_pkg::PC_W+bptc_pkg::SENS_SHIFT){dtc3_s2[bptc_pkg::PC_W-1]}},
			dtc3_s2[bptc_pkg::PC_W-1:bptc_pkg::SENS_SHIFT]};

		// Stage 4: squares for the second-order terms and the final temperature.
		d1_s4    <= d1_s3;
		off_s4   <= off_s3;
		sens_s4  <= sens_s3;
		dsq_s4   <= dsq_c[bptc_pkg::SQ_W-1:0];
		esq_s4   <= esq_c[bptc_pkg::SQ_W-1:0];
		cold_s4  <= d_s3[bptc_pkg::D_W-1];
		vcold_s4 <= e_c[bptc_pkg::E_W-1];
		temp_s4  <= temp_c;

		// Stage 5: second-order corrections.
		d1_s5    <= d1_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		temp_s5  <= temp_s4;
		off2_s5  <= off2_c;
		sens2_s5 <= sens2_c;

		// Stage 6: corrected offset and sensitivity.
		d1_s6   <= d1_s5;
		temp_s6 <= temp_s5;
		off_s6  <= off_s5 - $signed({{(bptc_pkg::OFF_W-bptc_pkg::CORR_W){1'b0}}, off2_s5});
		sens_s6 <= sens_s5 - $signed(sens2_s5);

		// Stage 7: D1 times SENS as two partial products.
		temp_s7 <= temp_s6;
		off_s7  <= off_s6;
		plo_s7  <= bptc_pkg::PLO_W'(d1_s6) * bptc_pkg::PLO_W'(sens_s6[bptc_pkg::LO_W-1:0]);
		phi_s7  <= $signed({1'b0, d1_s6}) * $signed(sens_s6[bptc_pkg::SENS_W-1:bptc_pkg::LO_W]);

		// Stage 8: recombine the partial products.
		temp_s8 <= temp_s7;
		off_s8  <= off_s7;
		prod_s8 <= ($signed(bptc_pkg::PROD_W'(phi_s7)) <<< bptc_pkg::LO_W)
			+ $signed({{(bptc_pkg::PROD_W-bptc_pkg::PLO_W){1'b0}}, plo_s7});

		// Stage 9: pressure, held in the output register.
		temp_s9 <= temp_s8;
		pres_s9 <= bptc_pkg::OUT_W'(pres_wide_c >>> bptc_pkg::P_SHIFT);
	end

	assign done                 = vld_s9;
	assign temperature_centideg = bptc_pkg::OUT_W'(temp_s9);
	assign pressure_pa          = pres_s9;

`ifndef SYNTHESIS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(bptc_pkg::LATENCY) done)
		else $error("accepted word did not produce a result on time");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, bptc_pkg::LATENCY))
		else $error("result strobe without a matching accepted word");

	a_cold_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && vcold_s4) |-> cold_s4)
		else $error("below -15 degC flagged without the 20 degC flag");

	a_warm_nocorr: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !cold_s4) |=> (off2_s5 == '0 && sens2_s5 == '0))
		else $error("second-order correction applied above 20 degC");
`endif

endmodule
